// File: design/bpcd_pkg.sv
package bpcd_pkg;

    localparam int MAX_PLANES      = 6;
    localparam int PALETTE_ENTRIES = 32;
    localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
    localparam int COLOR12_W       = 12;
    localparam int RGB_W           = 24;
    localparam int PLANE_CNT_W     = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = PLANE_CNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAM_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DPF_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_ENABLE = 2'd3;

    // Word kinds on the input tuser
    localparam logic MODE_PIXEL  = 1'b0;
    localparam logic MODE_PALWR  = 1'b1;

    // Hold-and-modify commands, plane bits 5:4
    localparam logic [1:0] HAM_LOAD  = 2'd0;
    localparam logic [1:0] HAM_BLUE  = 2'd1;
    localparam logic [1:0] HAM_RED   = 2'd2;
    localparam logic [1:0] HAM_GREEN = 2'd3;

    localparam logic [RGB_W-1:0] HALF_MASK = 24'h7F7F7F;

    typedef logic [COLOR12_W-1:0] color12_t;
    typedef logic [RGB_W-1:0]     rgb_t;

    // Widen a 12-bit color to 24 bits by nibble replication
    function automatic rgb_t widen12(input color12_t c);
        widen12 = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
    endfunction

endpackage

// File: design/bitplane_pixel_color_decode.sv
// Bitplane pixel color decoder: palette lookup, dual playfield, HAM and half-brite.
// An accepted pixel word's rgb word appears on m_tdata in the next cycle, from rgb_reg.
// Throughput: one word per cycle unless m_tready stalls; palette writes take a slot, give no output.
// The HAM held color feeds back through a single register, held_reg.
// Reset (aresetn low, synchronous): palette and held color cleared, display enabled,
// other configuration cleared, output empty.
module bitplane_pixel_color_decode (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [bpcd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpcd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [23:0]                           s_tdata,  // plane_bits, palette_index, palette_value
    input  logic [1:0]                            s_tuser,  // mode, row_start
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bpcd_pkg::RGB_W-1:0]            m_tdata   // rgb
);

    localparam int PW = bpcd_pkg::PAL_IDX_W;

    logic [bpcd_pkg::PLANE_CNT_W-1:0] plane_count_reg;
    logic                             ham_en_reg;
    logic                             dpf_en_reg;
    logic                             disp_en_reg;

    bpcd_pkg::color12_t palette_reg [bpcd_pkg::PALETTE_ENTRIES];
    bpcd_pkg::rgb_t     held_reg, held_next;
    bpcd_pkg::rgb_t     rgb_reg, rgb_next;
    logic               valid_reg;

    logic                      in_fire;
    logic                      in_mode;
    logic                      in_row;
    logic [5:0]                in_bits;
    logic [PW-1:0]             in_pidx;
    bpcd_pkg::color12_t        in_pval;

    logic [bpcd_pkg::PLANE_CNT_W-1:0] used;
    logic [5:0]                bits;
    logic                      ham, dual, ehb;
    logic [2:0]                pf1, pf2;
    logic [PW-1:0]             look_idx;
    bpcd_pkg::rgb_t            look_rgb;
    bpcd_pkg::rgb_t            base_held;
    bpcd_pkg::rgb_t            ham_rgb;
    logic [7:0]                ch;

    assign in_mode  = s_tuser[0];
    assign in_row   = s_tuser[1];
    assign in_bits  = s_tdata[5:0];
    assign in_pidx  = s_tdata[6 +: PW];
    assign in_pval  = s_tdata[6+PW +: bpcd_pkg::COLOR12_W];

    // Output register frees up when empty or being drained
    assign s_tready = !valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = rgb_reg;

    always_comb begin
        used = (plane_count_reg > bpcd_pkg::PLANE_CNT_W'(bpcd_pkg::MAX_PLANES))
             ? bpcd_pkg::PLANE_CNT_W'(bpcd_pkg::MAX_PLANES) : plane_count_reg;
        for (int i = 0; i < 6; i++) begin
            bits[i] = in_bits[i] && (bpcd_pkg::PLANE_CNT_W'(i) < used);
        end
        ham  = ham_en_reg && (used >= 3'd5);
        dual = dpf_en_reg && !ham;
        ehb  = !ham && !dual && (used == 3'd6);

        pf1 = {bits[4], bits[2], bits[0]};
        pf2 = {bits[5], bits[3], bits[1]};

        priority if (dual) begin
            if (pf1 != 3'd0) begin
                look_idx = {2'b00, pf1};
            end else if (pf2 != 3'd0) begin
                look_idx = {2'b01, pf2};
            end else begin
                look_idx = '0;
            end
        end else if (ham) begin
            look_idx = {1'b0, bits[3:0]};
        end else begin
            look_idx = bits[PW-1:0];
        end

        look_rgb  = bpcd_pkg::widen12(palette_reg[look_idx]);
        base_held = in_row ? bpcd_pkg::widen12(palette_reg[0]) : held_reg;
        ch        = {bits[3:0], bits[3:0]};

        unique case (bits[5:4])
            bpcd_pkg::HAM_LOAD:  ham_rgb = look_rgb;
            bpcd_pkg::HAM_BLUE:  ham_rgb = {base_held[23:8], ch};
            bpcd_pkg::HAM_RED:   ham_rgb = {ch, base_held[15:0]};
            bpcd_pkg::HAM_GREEN: ham_rgb = {base_held[23:16], ch, base_held[7:0]};
            default:             ham_rgb = look_rgb;
        endcase

        held_next = held_reg;
        rgb_next  = rgb_reg;
        if (in_fire && (in_mode == bpcd_pkg::MODE_PIXEL)) begin
            if (!disp_en_reg) begin
                rgb_next = '0;
            end else begin
                priority if (ham) begin
                    held_next = ham_rgb;
                    rgb_next  = ham_rgb;
                end else if (ehb && bits[5]) begin
                    held_next = base_held;
                    rgb_next  = (look_rgb >> 1) & bpcd_pkg::HALF_MASK;
                end else begin
                    held_next = base_held;
                    rgb_next  = look_rgb;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_count_reg <= '0;
            ham_en_reg      <= 1'b0;
            dpf_en_reg      <= 1'b0;
            disp_en_reg     <= 1'b1;
            held_reg        <= '0;
            valid_reg       <= 1'b0;
            for (int i = 0; i < bpcd_pkg::PALETTE_ENTRIES; i++) begin
                palette_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bpcd_pkg::CFG_PLANE_COUNT: plane_count_reg <= cfg_wdata;
                    bpcd_pkg::CFG_HAM_ENABLE:  ham_en_reg      <= cfg_wdata[0];
                    bpcd_pkg::CFG_DPF_ENABLE:  dpf_en_reg      <= cfg_wdata[0];
                    bpcd_pkg::CFG_DISP_ENABLE: disp_en_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (in_fire && (in_mode == bpcd_pkg::MODE_PALWR)) begin
                palette_reg[in_pidx] <= in_pval;
            end
            held_reg <= held_next;
            // hold a stalled word, advance on a pixel, drop on a drain
            if (in_fire) begin
                valid_reg <= (in_mode == bpcd_pkg::MODE_PIXEL);
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rgb_reg <= rgb_next;
    end

endmodule

// File: design/bpcd_checker.sv
module bpcd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [1:0]                   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bpcd_pkg::RGB_W-1:0]   m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_pixel_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == bpcd_pkg::MODE_PIXEL) |=> m_tvalid)
        else $error("pixel word gave no result");

    a_palwr_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == bpcd_pkg::MODE_PALWR) |=> !m_tvalid)
        else $error("palette write gave a result");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind bitplane_pixel_color_decode bpcd_checker u_bpcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/pixel_color_checker.sv
module pixel_color_checker
    import bpcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,  // plane_bits, palette_index, palette_value
    input  logic [1:0]            s_tuser,  // mode, row_start
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [RGB_W-1:0]      m_tdata,  // rgb
    output int                    pending,
    output int                    errors
);
    timeunit 1ns;
    timeprecision 1ps;

    color12_t         palette_mem [PALETTE_ENTRIES];
    rgb_t             held_rgb;
    logic [2:0]       plane_cnt;
    logic             ham_en;
    logic             dpf_en;
    logic             disp_en;
    rgb_t             rgb_due [$];
    int               err_cnt = 0;

    assign errors = err_cnt;

    // Look up an entry and stretch each nibble to a full byte
    function automatic rgb_t entry_rgb24(input logic [PAL_IDX_W-1:0] idx);
        color12_t c;
        rgb_t     r;
        c = palette_mem[idx];
        r = '0;
        for (int k = 0; k < 3; k++) begin
            r[8*k +: 8] = {c[4*k +: 4], c[4*k +: 4]};
        end
        return r;
    endfunction

    task automatic predict_rgb(input logic [5:0] raw_bits, input logic row, output rgb_t px);
        logic [2:0] used;
        logic [5:0] b;
        logic       ham_on;
        logic       dpf_on;
        logic       ehb_on;
        logic [2:0] pf1;
        logic [2:0] pf2;
        logic [7:0] chan;
        if (!disp_en) begin
            px = '0;
        end else begin
            used   = (plane_cnt > MAX_PLANES) ? 3'(MAX_PLANES) : plane_cnt;
            b      = raw_bits & ((6'd1 << used) - 6'd1);
            ham_on = ham_en && (used >= 3'd5);
            dpf_on = dpf_en && !ham_on;
            ehb_on = !ham_on && !dpf_on && (used == 3'd6);
            if (row) begin
                held_rgb = entry_rgb24(5'd0);
            end
            if (dpf_on) begin
                pf1 = {b[4], b[2], b[0]};
                pf2 = {b[5], b[3], b[1]};
                if (pf1 != 3'd0) begin
                    px = entry_rgb24({2'b00, pf1});
                end else if (pf2 != 3'd0) begin
                    px = entry_rgb24(5'd8 + {2'b00, pf2});
                end else begin
                    px = entry_rgb24(5'd0);
                end
            end else if (ham_on) begin
                chan = {b[3:0], b[3:0]};
                case (b[5:4])
                    HAM_LOAD:  held_rgb = entry_rgb24({1'b0, b[3:0]});
                    HAM_BLUE:  held_rgb[7:0] = chan;
                    HAM_RED:   held_rgb[23:16] = chan;
                    default:   held_rgb[15:8] = chan;
                endcase
                px = held_rgb;
            end else if (ehb_on && b[5]) begin
                px = (entry_rgb24(b[4:0]) >> 1) & HALF_MASK;
            end else begin
                px = entry_rgb24(b[4:0]);
            end
        end
    endtask

    always @(posedge aclk) begin
        rgb_t px;
        rgb_t want;
        if (!aresetn) begin
            foreach (palette_mem[i]) palette_mem[i] = '0;
            held_rgb  = '0;
            plane_cnt = '0;
            ham_en    = 1'b0;
            dpf_en    = 1'b0;
            disp_en   = 1'b1;
            rgb_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PLANE_COUNT: plane_cnt = cfg_wdata[2:0];
                    CFG_HAM_ENABLE:  ham_en    = cfg_wdata[0];
                    CFG_DPF_ENABLE:  dpf_en    = cfg_wdata[0];
                    CFG_DISP_ENABLE: disp_en   = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_PALWR) begin
                    palette_mem[s_tdata[10:6]] = s_tdata[22:11];
                end else begin
                    predict_rgb(s_tdata[5:0], s_tuser[1], px);
                    rgb_due.push_back(px);
                end
            end
            if (m_tvalid && m_tready) begin
                if (rgb_due.size() == 0) begin
                    $display("%0t: unexpected rgb word, expected none, got %06h",
                             $time, m_tdata);
                    err_cnt++;
                end else begin
                    want = rgb_due.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: rgb mismatch, expected %06h, got %06h",
                                 $time, want, m_tdata);
                        err_cnt++;
                    end
                end
            end
        end
        pending <= rgb_due.size();
    end

endmodule

// File: tb/bitplane_pixel_color_decode_test.sv
module bitplane_pixel_color_decode_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bpcd_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;  // plane_bits, palette_index, palette_value
    logic [1:0]            s_tuser;  // mode, row_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [RGB_W-1:0]      m_tdata;  // rgb
    int                    pending;
    int                    errors;
    logic                  no_gaps = 1'b0;

    bitplane_pixel_color_decode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pixel_color_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .pending   (pending),
        .errors    (errors)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: drop m_tready at random before taking each word, unless no_gaps is set
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_word(input logic mode, input logic [5:0] bits, input logic row,
                             input logic [4:0] idx, input logic [11:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, idx, bits};
        s_tuser  <= {row, mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_pixel(input logic [5:0] bits, input logic row);
        send_word(MODE_PIXEL, bits, row, 5'($urandom), 12'($urandom));
    endtask

    task automatic write_entry(input logic [4:0] idx, input logic [11:0] val);
        send_word(MODE_PALWR, 6'($urandom), 1'($urandom), idx, val);
    endtask

    // Hold until every predicted word has come back, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [2:0] pc, input logic hm, input logic dp,
                                input logic de);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_PLANE_COUNT, CFG_HAM_ENABLE, CFG_DPF_ENABLE, CFG_DISP_ENABLE};
        // flag registers get junk in the unused upper bits
        val = '{pc, {2'($urandom), hm}, {2'($urandom), dp}, {2'($urandom), de}};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [2:0] mode_pc [8];
        logic [2:0] mode_flags [8];
        logic [2:0] pc;
        logic [2:0] flags;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state: no planes, empty palette
        send_pixel(6'h3F, 1'b1);
        write_entry(5'd0, 12'h000);
        write_entry(5'd31, 12'hFFF);
        write_entry(5'd21, 12'h5A3);
        write_entry(5'd1, 12'h123);
        write_entry(5'd9, 12'hE6C);
        write_entry(5'd5, 12'h8F1);
        drain();

        // half-brite with plane count seven
        program_regs(3'd7, 1'b0, 1'b0, 1'b1);
        send_pixel(6'h3F, 1'b0);
        send_pixel(6'h15, 1'b0);
        send_pixel(6'h35, 1'b0);
        send_pixel(6'h00, 1'b1);
        drain();

        // dual playfield: transparent, front, back, both, back only at max
        program_regs(3'd6, 1'b0, 1'b1, 1'b1);
        send_pixel(6'h00, 1'b0);
        send_pixel(6'h01, 1'b0);
        send_pixel(6'h02, 1'b0);
        send_pixel(6'h3F, 1'b0);
        send_pixel(6'h2A, 1'b0);
        drain();

        // HAM6: load, then modify each channel, row restarts
        program_regs(3'd6, 1'b1, 1'b0, 1'b1);
        send_pixel(6'h05, 1'b1);
        send_pixel(6'h1F, 1'b0);
        send_pixel(6'h20, 1'b0);
        send_pixel(6'h3A, 1'b0);
        send_pixel(6'h2C, 1'b1);
        drain();

        // HAM5 wins over dual playfield, top plane masked
        program_regs(3'd5, 1'b1, 1'b1, 1'b1);
        send_pixel(6'h3F, 1'b1);
        drain();

        // display off: black, and the row start must leave the held color alone
        program_regs(3'd3, 1'b0, 1'b0, 1'b0);
        send_pixel(6'h3F, 1'b1);
        drain();
        program_regs(3'd6, 1'b1, 1'b0, 1'b1);
        send_pixel(6'h1A, 1'b0);
        drain();

        // random phases: fixed corner settings first, then random ones
        mode_pc    = '{3'd7, 3'd5, 3'd6, 3'd6, 3'd0, 3'd4, 3'd7, 3'd2};
        // flags: {display, dual playfield, ham}
        mode_flags = '{3'b101, 3'b111, 3'b110, 3'b100, 3'b100, 3'b110, 3'b001, 3'b101};
        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 8) begin
                pc    = mode_pc[ph];
                flags = mode_flags[ph];
            end else begin
                pc    = 3'($urandom);
                flags = {1'b1, 2'($urandom)};
            end
            drain();
            program_regs(pc, flags[0], flags[1], flags[2]);
            no_gaps = (ph == 3) || (ph == 7);
            for (int n = 0; n < 125; n++) begin
                if (n == 62) begin
                    drain();
                end
                if ($urandom_range(0, 5) == 0) begin
                    write_entry(5'($urandom), 12'($urandom));
                end else begin
                    send_pixel(6'($urandom), $urandom_range(0, 15) == 0);
                end
            end
        end
        no_gaps = 1'b0;
        drain();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
